/* rtl/nse_pkg.sv */
// Shared types and constants for the NMEA sentence extractor.
package nse_pkg;

	localparam int LEN_W     = 7;
	localparam int CNT_W     = 7;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_RMC = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GGA = 2'd1;

	localparam logic ACT_FEED = 1'b0;
	localparam logic ACT_READ = 1'b1;

	localparam logic KIND_RMC = 1'b0;
	localparam logic KIND_GGA = 1'b1;

	localparam logic [1:0] RK_SENTENCE = 2'd0;
	localparam logic [1:0] RK_SCAN     = 2'd1;
	localparam logic [1:0] RK_READ     = 2'd2;

	localparam logic [1:0] MASK_RMC  = 2'b01;
	localparam logic [1:0] MASK_GGA  = 2'b10;
	localparam logic [1:0] MASK_BOTH = 2'b11;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;

	localparam logic [2:0]       HDR_LAST  = 3'd6;
	localparam logic [LEN_W-1:0] HDR_CHARS = 7'd7;
	localparam logic [CNT_W-1:0] HDR_COMMAS = 7'd1;

	localparam logic [CNT_W-1:0] RMC_COMMAS_RST = 7'd11;
	localparam logic [CNT_W-1:0] GGA_COMMAS_RST = 7'd14;

	typedef enum logic [1:0] {
		PH_SEARCH,
		PH_HEADER,
		PH_COPY,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic             stype;
		logic             svalid;
		logic [LEN_W-1:0] slen;
		logic [1:0]       mask;
	} res_t;

	// "$GPRMC," / "$GPGGA,"
	function automatic logic [7:0] hdr_char(input logic gga, input logic [2:0] pos);
		logic [7:0] c;
		unique case (pos)
			3'd0: c = CH_DOLLAR;
			3'd1: c = 8'h47;
			3'd2: c = 8'h50;
			3'd3: c = gga ? 8'h47 : 8'h52;
			3'd4: c = gga ? 8'h47 : 8'h4D;
			3'd5: c = gga ? 8'h41 : 8'h43;
			default: c = CH_COMMA;
		endcase
		return c;
	endfunction

endpackage

/* rtl/nse_ifs.sv */
// Handshake channel interfaces: configuration, input feed and results.
interface nse_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [nse_pkg::CFG_IDX_W-1:0] index;
	logic [nse_pkg::CNT_W-1:0]     data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

interface nse_feed_if;
	logic                       valid;
	logic                       ready;
	logic                       action;
	logic [7:0]                 data_byte;
	logic                       end_of_buffer;
	logic                       read_kind;
	logic [nse_pkg::LEN_W-1:0] read_index;

	modport source(output valid, output action, output data_byte, output end_of_buffer,
		output read_kind, output read_index, input ready);
	modport sink(input valid, input action, input data_byte, input end_of_buffer,
		input read_kind, input read_index, output ready);
endinterface

interface nse_res_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 result_kind;
	logic                       sentence_type;
	logic                       sentence_valid;
	logic [nse_pkg::LEN_W-1:0] sentence_length;
	logic [1:0]                 found_mask;
	logic [7:0]                 read_byte;
	logic                       last;

	modport source(output valid, output result_kind, output sentence_type,
		output sentence_valid, output sentence_length, output found_mask,
		output read_byte, output last, input ready);
	modport sink(input valid, input result_kind, input sentence_type,
		input sentence_valid, input sentence_length, input found_mask,
		input read_byte, input last, output ready);
endinterface

/* rtl/nmea_sentence_extractor.sv */
// NMEA sentence extractor: $GPRMC / $GPGGA header match, copy into per-type stores, readback.
// Takes one transaction per cycle on feed while the sink keeps up. Every feed or read
// transaction is decoded in its accept cycle and its results are registered in one output
// register; a read also fetches its store byte from a synchronous memory on the same clock
// edge. The one case that costs throughput is an end-of-buffer byte that also finishes a
// sentence: its two results leave the output register in two transfers and feed is held
// off until the first of them has been taken. Each store keeps a length register that marks
// its first NUL, so reset needs no clearing pass over the memories and reads at or past
// that length return zero. Configuration writes are always taken.
module nmea_sentence_extractor #(
	parameter int SENTENCE_MAX = 80
) (
	input logic        clk,
	input logic        arst_n,
	nse_cfg_if.sink    cfg,
	nse_feed_if.sink   feed,
	nse_res_if.source  result
);

	localparam int LW = $clog2(SENTENCE_MAX + 1);
	localparam int CW = (LW > nse_pkg::LEN_W) ? LW : nse_pkg::LEN_W;
	localparam logic [LW-1:0] POS_MAX = LW'(SENTENCE_MAX);

	logic [nse_pkg::CNT_W-1:0] rmc_need_q, gga_need_q;

	nse_pkg::phase_t phase_q, phase_d;
	logic [2:0]      hpos_q, hpos_d;
	logic            rmc_m_q, rmc_m_d, gga_m_q, gga_m_d;
	logic [LW-1:0]   cpos_q, cpos_d, commas_q, commas_d;
	logic [1:0]      acc_q, acc_d;
	logic [LW-1:0]   rmc_len_q, rmc_len_d, gga_len_q, gga_len_d;

	logic [7:0] rmc_mem [SENTENCE_MAX+1];
	logic [7:0] gga_mem [SENTENCE_MAX+1];

	logic          feed_acc, feed_go, read_go;
	logic [7:0]    b;
	logic          rm_t, gm_t, start, fin, valid_fin;
	logic          we_rmc, we_gga;
	logic [LW-1:0] fin_len;
	logic [1:0]    acc_scan;
	logic [nse_pkg::CNT_W-1:0] need;

	nse_pkg::res_t r0, r1;
	logic [1:0]    nres;

	logic [CW-1:0] rd_idx_x;
	logic [LW-1:0] rd_addr, rd_len;

	logic          v_s1, two_s1, head_q;
	nse_pkg::res_t res0_s1, res1_s1, cur;
	logic          rd_hit_s1, rd_hdr_s1, rd_kind_s1;
	logic [7:0]    rd_hbyte_s1, rmc_rd_s1, gga_rd_s1;

	// configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rmc_need_q <= nse_pkg::RMC_COMMAS_RST;
			gga_need_q <= nse_pkg::GGA_COMMAS_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				nse_pkg::CFG_RMC: rmc_need_q <= cfg.data;
				nse_pkg::CFG_GGA: gga_need_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// input handshake
	assign feed.ready = !v_s1 || (result.ready && (!two_s1 || head_q));
	assign feed_acc   = feed.valid && feed.ready;
	assign feed_go    = feed_acc && (feed.action == nse_pkg::ACT_FEED);
	assign read_go    = feed_acc && (feed.action == nse_pkg::ACT_READ);
	assign b          = feed.data_byte;
	assign need       = rmc_m_q ? rmc_need_q : gga_need_q;

	// next state
	always_comb begin
		phase_d   = phase_q;
		hpos_d    = hpos_q;
		rmc_m_d   = rmc_m_q;
		gga_m_d   = gga_m_q;
		cpos_d    = cpos_q;
		commas_d  = commas_q;
		acc_d     = acc_q;
		rmc_len_d = rmc_len_q;
		gga_len_d = gga_len_q;
		we_rmc    = 1'b0;
		we_gga    = 1'b0;
		start     = 1'b0;
		fin       = 1'b0;
		valid_fin = 1'b0;
		rm_t      = rmc_m_q && (b == nse_pkg::hdr_char(nse_pkg::KIND_RMC, hpos_q));
		gm_t      = gga_m_q && (b == nse_pkg::hdr_char(nse_pkg::KIND_GGA, hpos_q));
		if (feed_go) begin
			unique case (phase_q)
				nse_pkg::PH_SEARCH: start = (b == nse_pkg::CH_DOLLAR);
				nse_pkg::PH_HEADER: begin
					rmc_m_d = rm_t;
					gga_m_d = gm_t;
					if (!rm_t && !gm_t) begin
						phase_d = nse_pkg::PH_SEARCH;
						hpos_d  = 3'd0;
						start   = (b == nse_pkg::CH_DOLLAR);
					end else if (hpos_q == nse_pkg::HDR_LAST) begin
						phase_d  = nse_pkg::PH_COPY;
						cpos_d   = LW'(nse_pkg::HDR_CHARS);
						commas_d = LW'(nse_pkg::HDR_COMMAS);
						if (rm_t) begin
							rmc_len_d = LW'(nse_pkg::HDR_CHARS);
						end else begin
							gga_len_d = LW'(nse_pkg::HDR_CHARS);
						end
					end else begin
						hpos_d = hpos_q + 3'd1;
					end
				end
				nse_pkg::PH_COPY: begin
					if (b == nse_pkg::CH_NUL || b == nse_pkg::CH_STAR ||
					    b == nse_pkg::CH_CR || b == nse_pkg::CH_LF) begin
						fin = 1'b1;
					end else begin
						if (cpos_q < POS_MAX) begin
							we_rmc   = rmc_m_q;
							we_gga   = !rmc_m_q;
							cpos_d   = cpos_q + 1'b1;
							commas_d = commas_q + LW'(b == nse_pkg::CH_COMMA);
							if (rmc_m_q) begin
								rmc_len_d = cpos_d;
							end else begin
								gga_len_d = cpos_d;
							end
						end
						fin = (cpos_d == POS_MAX);
					end
				end
				nse_pkg::PH_DONE: ;
				default: ;
			endcase
			if (start) begin
				hpos_d  = 3'd1;
				rmc_m_d = !acc_q[0];
				gga_m_d = !acc_q[1];
				phase_d = (acc_q == nse_pkg::MASK_BOTH) ? nse_pkg::PH_SEARCH
				                                        : nse_pkg::PH_HEADER;
			end
			if (fin) begin
				valid_fin = (CW'(commas_d) == CW'(need));
				if (valid_fin) begin
					acc_d = acc_q | (rmc_m_q ? nse_pkg::MASK_RMC : nse_pkg::MASK_GGA);
				end
				phase_d = (acc_d == nse_pkg::MASK_BOTH) ? nse_pkg::PH_DONE
				                                        : nse_pkg::PH_SEARCH;
				hpos_d  = 3'd0;
			end
		end
		fin_len  = cpos_d;
		acc_scan = acc_d;
		if (feed_go && feed.end_of_buffer) begin
			phase_d  = nse_pkg::PH_SEARCH;
			hpos_d   = 3'd0;
			rmc_m_d  = 1'b0;
			gga_m_d  = 1'b0;
			cpos_d   = '0;
			commas_d = '0;
			acc_d    = 2'b00;
		end
	end

	// results of the accepted transaction
	always_comb begin
		r0   = '0;
		r1   = '0;
		nres = 2'd0;
		if (read_go) begin
			r0.kind = nse_pkg::RK_READ;
			nres    = 2'd1;
		end else if (feed_go) begin
			if (fin) begin
				r0.kind   = nse_pkg::RK_SENTENCE;
				r0.stype  = rmc_m_q ? nse_pkg::KIND_RMC : nse_pkg::KIND_GGA;
				r0.svalid = valid_fin;
				r0.slen   = nse_pkg::LEN_W'(CW'(fin_len));
				r0.mask   = acc_scan;
				nres      = 2'd1;
			end
			if (feed.end_of_buffer) begin
				if (fin) begin
					r1.kind = nse_pkg::RK_SCAN;
					r1.mask = acc_scan;
					nres    = 2'd2;
				end else begin
					r0.kind = nse_pkg::RK_SCAN;
					r0.mask = acc_scan;
					nres    = 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= nse_pkg::PH_SEARCH;
			hpos_q    <= 3'd0;
			rmc_m_q   <= 1'b0;
			gga_m_q   <= 1'b0;
			cpos_q    <= '0;
			commas_q  <= '0;
			acc_q     <= 2'b00;
			rmc_len_q <= '0;
			gga_len_q <= '0;
		end else begin
			phase_q   <= phase_d;
			hpos_q    <= hpos_d;
			rmc_m_q   <= rmc_m_d;
			gga_m_q   <= gga_m_d;
			cpos_q    <= cpos_d;
			commas_q  <= commas_d;
			acc_q     <= acc_d;
			rmc_len_q <= rmc_len_d;
			gga_len_q <= gga_len_d;
		end
	end

	// sentence stores; header bytes are not stored, they come from the constant table
	assign rd_idx_x = CW'(feed.read_index);
	assign rd_addr  = rd_idx_x[LW-1:0];
	assign rd_len   = feed.read_kind ? gga_len_q : rmc_len_q;

	always_ff @(posedge clk) begin
		if (we_rmc) begin
			rmc_mem[cpos_q] <= b;
		end
		if (read_go) begin
			rmc_rd_s1 <= rmc_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (we_gga) begin
			gga_mem[cpos_q] <= b;
		end
		if (read_go) begin
			gga_rd_s1 <= gga_mem[rd_addr];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			two_s1 <= 1'b0;
			head_q <= 1'b0;
		end else if (feed_acc && nres != 2'd0) begin
			v_s1   <= 1'b1;
			two_s1 <= (nres == 2'd2);
			head_q <= 1'b0;
		end else if (result.valid && result.ready) begin
			if (two_s1 && !head_q) begin
				head_q <= 1'b1;
			end else begin
				v_s1   <= 1'b0;
				head_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (feed_acc && nres != 2'd0) begin
			res0_s1 <= r0;
			res1_s1 <= r1;
		end
		if (read_go) begin
			rd_hit_s1   <= rd_idx_x < CW'(rd_len);
			rd_hdr_s1   <= feed.read_index < nse_pkg::HDR_CHARS;
			rd_kind_s1  <= feed.read_kind;
			rd_hbyte_s1 <= nse_pkg::hdr_char(feed.read_kind, feed.read_index[2:0]);
		end
	end

	assign cur                    = head_q ? res1_s1 : res0_s1;
	assign result.valid           = v_s1;
	assign result.result_kind     = cur.kind;
	assign result.sentence_type   = cur.stype;
	assign result.sentence_valid  = cur.svalid;
	assign result.sentence_length = cur.slen;
	assign result.found_mask      = cur.mask;
	assign result.last            = !two_s1 || head_q;
	assign result.read_byte       = (cur.kind == nse_pkg::RK_READ && rd_hit_s1) ?
		(rd_hdr_s1 ? rd_hbyte_s1 : (rd_kind_s1 ? gga_rd_s1 : rmc_rd_s1)) : 8'h00;

	a_copy_one_type: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == nse_pkg::PH_COPY |-> (rmc_m_q ^ gga_m_q))
		else $error("copy phase without exactly one header match");

	a_copy_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cpos_q <= POS_MAX && commas_q <= cpos_q)
		else $error("copy position or comma count out of range");

	a_both_done: assert property (@(posedge clk) disable iff (!arst_n)
		acc_q == nse_pkg::MASK_BOTH |-> phase_q == nse_pkg::PH_DONE)
		else $error("both types accepted but parser still active");

	a_len_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		(rmc_len_q == '0 || CW'(rmc_len_q) >= CW'(nse_pkg::HDR_CHARS)) &&
		(gga_len_q == '0 || CW'(gga_len_q) >= CW'(nse_pkg::HDR_CHARS)))
		else $error("store length shorter than a header");

	a_second_slot: assert property (@(posedge clk) disable iff (!arst_n)
		head_q |-> (v_s1 && two_s1))
		else $error("second result selected without a pair pending");

endmodule

/* bench/tb_top.sv */
// Testbench for nmea_sentence_extractor: directed table plus random NMEA scans against a predictor.
`timescale 1ns / 1ps

module tb_top;
	import nse_pkg::*;

	localparam int MAX_CHARS = 80;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 30;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
	localparam logic [55:0] RMC_HEADER = "$GPRMC,";
	localparam logic [55:0] GGA_HEADER = "$GPGGA,";

	typedef struct packed {
		logic             action;
		logic [7:0]       data_byte;
		logic             eob;
		logic             read_kind;
		logic [LEN_W-1:0] read_index;
	} feed_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic             stype;
		logic             svalid;
		logic [LEN_W-1:0] slen;
		logic [1:0]       mask;
		logic [7:0]       rbyte;
		logic             last;
	} nmea_res_t;

	typedef struct packed {
		feed_t     item;
		logic      typed;
		nmea_res_t res;
	} row_t;

	logic clk;
	logic arst_n;

	nse_cfg_if  cfg_ch();
	nse_feed_if feed_ch();
	nse_res_if  res_ch();

	nmea_sentence_extractor #(.SENTENCE_MAX(MAX_CHARS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.feed   (feed_ch),
		.result (res_ch)
	);

	// sentence predictor state
	logic [7:0]       sentence_text [2][0:MAX_CHARS];
	phase_t           parse_ph;
	int               hdr_pos;
	logic             rmc_hit;
	logic             gga_hit;
	int               copy_len;
	int               comma_cnt;
	logic [1:0]       found;
	logic [CNT_W-1:0] rmc_commas;
	logic [CNT_W-1:0] gga_commas;

	nmea_res_t expected_q[$];
	nmea_res_t step_q[$];
	logic [7:0] scan_text[$];
	row_t      dir_rows[$];
	nmea_res_t mon_want;

	int errors = 0;
	int cycles = 0;
	int item_count = 0;
	int settings_cnt = 0;
	int n_sentence = 0;
	int n_accepted = 0;
	int n_scan = 0;
	int n_read = 0;
	int stall_left = 0;
	bit steady_feed = 0;
	bit steady_sink = 0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [7:0] header_char(logic gga, int p);
		return gga ? GGA_HEADER[55 - 8*p -: 8] : RMC_HEADER[55 - 8*p -: 8];
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 8);
		return $urandom_range(10, 30);
	endfunction

	function automatic int feed_gap();
		if (steady_feed || $urandom_range(0, 99) < 60)
			return 0;
		return gap_len();
	endfunction

	function automatic feed_t text_in(logic [7:0] b, logic eob);
		return '{ACT_FEED, b, eob, KIND_RMC, 7'd0};
	endfunction

	function automatic feed_t store_rd(logic kind, logic [LEN_W-1:0] idx);
		return '{ACT_READ, 8'h00, 1'b0, kind, idx};
	endfunction

	function automatic nmea_res_t rd_res(logic [7:0] v);
		return '{RK_READ, 1'b0, 1'b0, 7'd0, 2'b00, v, 1'b1};
	endfunction

	function automatic nmea_res_t scan_res(logic [1:0] m);
		return '{RK_SCAN, 1'b0, 1'b0, 7'd0, m, 8'h00, 1'b1};
	endfunction

	task automatic clear_scan();
		parse_ph = PH_SEARCH;
		hdr_pos = 0;
		rmc_hit = 1'b0;
		gga_hit = 1'b0;
		copy_len = 0;
		comma_cnt = 0;
		found = 2'b00;
	endtask

	task automatic open_header();
		parse_ph = PH_HEADER;
		hdr_pos = 1;
		rmc_hit = (found & MASK_RMC) == 2'b00;
		gga_hit = (found & MASK_GGA) == 2'b00;
		if (!rmc_hit && !gga_hit)
			parse_ph = PH_SEARCH;
	endtask

	task automatic close_sentence();
		logic k;
		logic ok;
		k = rmc_hit ? KIND_RMC : KIND_GGA;
		ok = comma_cnt == int'(rmc_hit ? rmc_commas : gga_commas);
		if (copy_len <= MAX_CHARS)
			sentence_text[k][copy_len] = CH_NUL;
		if (ok)
			found = found | (rmc_hit ? MASK_RMC : MASK_GGA);
		step_q.push_back('{RK_SENTENCE, k, ok, LEN_W'(copy_len), found, 8'h00, 1'b0});
		parse_ph = (found == MASK_BOTH) ? PH_DONE : PH_SEARCH;
		hdr_pos = 0;
	endtask

	task automatic predict_step(feed_t it);
		logic [7:0] b;
		logic [7:0] v;
		logic k;
		int p;
		int i;
		nmea_res_t r;
		step_q.delete();
		b = it.data_byte;
		if (it.action == ACT_READ) begin
			v = 8'h00;
			if (it.read_index <= MAX_CHARS) begin
				v = sentence_text[it.read_kind][it.read_index];
				for (i = 0; i < it.read_index; i++)
					if (sentence_text[it.read_kind][i] == CH_NUL)
						v = 8'h00;
			end
			step_q.push_back('{RK_READ, 1'b0, 1'b0, 7'd0, 2'b00, v, 1'b0});
		end else begin
			case (parse_ph)
				PH_SEARCH: begin
					if (b == CH_DOLLAR)
						open_header();
				end
				PH_HEADER: begin
					p = (hdr_pos > int'(HDR_LAST)) ? int'(HDR_LAST) : hdr_pos;
					rmc_hit = rmc_hit && b == header_char(KIND_RMC, p);
					gga_hit = gga_hit && b == header_char(KIND_GGA, p);
					if (!rmc_hit && !gga_hit) begin
						parse_ph = PH_SEARCH;
						hdr_pos = 0;
						if (b == CH_DOLLAR)
							open_header();
					end else if (p == int'(HDR_LAST)) begin
						k = rmc_hit ? KIND_RMC : KIND_GGA;
						for (i = 0; i < int'(HDR_CHARS); i++)
							sentence_text[k][i] = header_char(k, i);
						sentence_text[k][HDR_CHARS] = CH_NUL;
						copy_len = int'(HDR_CHARS);
						comma_cnt = int'(HDR_COMMAS);
						parse_ph = PH_COPY;
					end else begin
						hdr_pos = p + 1;
					end
				end
				PH_COPY: begin
					if (b == CH_NUL || b == CH_STAR || b == CH_CR || b == CH_LF) begin
						close_sentence();
					end else begin
						k = rmc_hit ? KIND_RMC : KIND_GGA;
						if (copy_len < MAX_CHARS) begin
							sentence_text[k][copy_len] = b;
							sentence_text[k][copy_len + 1] = CH_NUL;
							copy_len++;
							if (b == CH_COMMA)
								comma_cnt++;
						end
						if (copy_len >= MAX_CHARS)
							close_sentence();
					end
				end
				default: ;
			endcase
			if (it.eob) begin
				step_q.push_back('{RK_SCAN, 1'b0, 1'b0, 7'd0, found, 8'h00, 1'b0});
				clear_scan();
			end
		end
		if (step_q.size() > 0) begin
			r = step_q.pop_back();
			r.last = 1'b1;
			step_q.push_back(r);
		end
	endtask

	task automatic put_item(feed_t it, logic typed, nmea_res_t typed_res);
		int g;
		g = feed_gap();
		repeat (g) begin
			@(negedge clk);
			feed_ch.valid <= 1'b0;
		end
		@(negedge clk);
		feed_ch.valid <= 1'b1;
		feed_ch.action <= it.action;
		feed_ch.data_byte <= it.data_byte;
		feed_ch.end_of_buffer <= it.eob;
		feed_ch.read_kind <= it.read_kind;
		feed_ch.read_index <= it.read_index;
		do @(posedge clk); while (!feed_ch.ready);
		item_count++;
		predict_step(it);
		if (typed)
			expected_q.push_back(typed_res);
		else
			foreach (step_q[i])
				expected_q.push_back(step_q[i]);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] val);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		if (idx == CFG_RMC)
			rmc_commas = val;
		else if (idx == CFG_GGA)
			gga_commas = val;
	endtask

	task automatic settle();
		@(negedge clk);
		feed_ch.valid <= 1'b0;
		while (expected_q.size() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	function automatic logic [7:0] filler();
		int r;
		r = $urandom_range(0, 99);
		if (r < 4)
			return CH_DOLLAR;
		if (r < 8)
			return 8'($urandom_range(8'h80, 8'hFF));
		return 8'($urandom_range(8'h2D, 8'h7E));
	endfunction

	function automatic logic [7:0] terminator();
		case ($urandom_range(0, 3))
			0: return CH_NUL;
			1: return CH_STAR;
			2: return CH_CR;
			default: return CH_LF;
		endcase
	endfunction

	task automatic add_sentence(logic gga, logic bad, logic long_one);
		logic [7:0] body[$];
		int need;
		int want;
		int len;
		int pos;
		int bad_pos;
		int i;
		bad_pos = bad ? $urandom_range(1, 6) : -1;
		for (i = 0; i < int'(HDR_CHARS); i++)
			scan_text.push_back(i == bad_pos ? 8'($urandom_range(0, 255)) : header_char(gga, i));
		need = int'(gga ? gga_commas : rmc_commas);
		if (need >= 1 && $urandom_range(0, 99) < 70)
			want = need - 1;
		else
			want = $urandom_range(0, need + 1);
		len = long_one ? $urandom_range(73, 80) : want + $urandom_range(0, 6);
		for (i = 0; i < len; i++)
			body.push_back(filler());
		for (i = 0; i < want && i < len; i++) begin
			do pos = $urandom_range(0, len - 1); while (body[pos] == CH_COMMA);
			body[pos] = CH_COMMA;
		end
		foreach (body[j])
			scan_text.push_back(body[j]);
		if (!long_one || $urandom_range(0, 1) == 0) begin
			if ($urandom_range(0, 99) < 92)
				scan_text.push_back(terminator());
		end
	endtask

	task automatic random_read();
		feed_t it;
		int r;
		r = $urandom_range(0, 99);
		it.action = ACT_READ;
		it.data_byte = 8'($urandom_range(0, 255));
		it.eob = 1'($urandom_range(0, 1));
		it.read_kind = 1'($urandom_range(0, 1));
		if (r < 70)
			it.read_index = LEN_W'($urandom_range(0, 20));
		else if (r < 90)
			it.read_index = LEN_W'($urandom_range(0, MAX_CHARS));
		else
			it.read_index = LEN_W'($urandom_range(MAX_CHARS + 1, 127));
		put_item(it, 1'b0, '0);
	endtask

	task automatic random_scan(logic force_long);
		int segs;
		int s;
		int r;
		int cut;
		int i;
		scan_text.delete();
		segs = $urandom_range(1, 4);
		for (s = 0; s < segs; s++) begin
			r = $urandom_range(0, 99);
			if (force_long && s == 0)
				add_sentence(1'($urandom_range(0, 1)), 1'b0, 1'b1);
			else if (r < 45)
				add_sentence(KIND_RMC, 1'b0, $urandom_range(0, 99) < 2);
			else if (r < 80)
				add_sentence(KIND_GGA, 1'b0, $urandom_range(0, 99) < 2);
			else if (r < 90)
				add_sentence(1'($urandom_range(0, 1)), 1'b1, 1'b0);
			else
				repeat ($urandom_range(1, 6)) scan_text.push_back(8'($urandom_range(0, 255)));
		end
		r = $urandom_range(0, 99);
		if (r < 15) begin
			// end of buffer lands mid-text, possibly inside a sentence
			cut = $urandom_range(1, scan_text.size());
			while (scan_text.size() > cut)
				void'(scan_text.pop_back());
		end else if (r < 35) begin
			scan_text.push_back(8'($urandom_range(0, 255)));
		end
		for (i = 0; i < scan_text.size(); i++) begin
			if ($urandom_range(0, 99) < 15)
				random_read();
			put_item(text_in(scan_text[i], i == scan_text.size() - 1), 1'b0, '0);
		end
	endtask

	task automatic run_phase(logic [CNT_W-1:0] rc, logic [CNT_W-1:0] gc, logic force_long);
		int start;
		logic first;
		settle();
		write_reg(CFG_RMC, rc);
		write_reg(CFG_GGA, gc);
		write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
			CNT_W'($urandom_range(0, 127)));
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		settings_cnt++;
		start = item_count;
		first = force_long;
		while (item_count - start < PHASE_ITEMS) begin
			random_scan(first);
			first = 1'b0;
		end
	endtask

	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk) begin
		cycles++;
		if ($urandom_range(0, 299) == 0)
			steady_feed = !steady_feed;
		if ($urandom_range(0, 299) == 0)
			steady_sink = !steady_sink;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, expected_q.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			res_ch.ready <= 1'b0;
		end else if (!steady_sink && $urandom_range(0, 99) < 25) begin
			stall_left = gap_len() - 1;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result transaction, kind %0d", $time,
					res_ch.result_kind);
			end else begin
				mon_want = expected_q.pop_front();
				check_field("result_kind", mon_want.kind, res_ch.result_kind);
				check_field("sentence_type", mon_want.stype, res_ch.sentence_type);
				check_field("sentence_valid", mon_want.svalid, res_ch.sentence_valid);
				check_field("sentence_length", mon_want.slen, res_ch.sentence_length);
				check_field("found_mask", mon_want.mask, res_ch.found_mask);
				check_field("read_byte", mon_want.rbyte, res_ch.read_byte);
				check_field("last", mon_want.last, res_ch.last);
				case (mon_want.kind)
					RK_SENTENCE: begin
						n_sentence++;
						if (mon_want.svalid)
							n_accepted++;
					end
					RK_SCAN: n_scan++;
					default: n_read++;
				endcase
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_RMC;
		cfg_ch.data = '0;
		feed_ch.valid = 1'b0;
		feed_ch.action = ACT_FEED;
		feed_ch.data_byte = 8'h00;
		feed_ch.end_of_buffer = 1'b0;
		feed_ch.read_kind = KIND_RMC;
		feed_ch.read_index = '0;
		res_ch.ready = 1'b0;

		foreach (sentence_text[k, i])
			sentence_text[k][i] = 8'h00;
		clear_scan();
		rmc_commas = RMC_COMMAS_RST;
		gga_commas = GGA_COMMAS_RST;

		// stores after reset, dollar restart, '$' and high-bit chars inside a sentence,
		// unknown header, NUL while searching
		dir_rows.push_back('{store_rd(KIND_GGA, 7'd0), 1'b1, rd_res(8'h00)});
		dir_rows.push_back('{store_rd(KIND_GGA, 7'd127), 1'b1, rd_res(8'h00)});
		dir_rows.push_back('{text_in(8'hFF, 1'b1), 1'b1, scan_res(2'b00)});
		dir_rows.push_back('{text_in(CH_DOLLAR, 1'b0), 1'b0, '0});
		dir_rows.push_back('{text_in(CH_DOLLAR, 1'b0), 1'b0, '0});
		dir_rows.push_back('{text_in("G", 1'b0), 1'b0, '0});
		dir_rows.push_back('{text_in("P", 1'b0), 1'b0, '0});
		dir_rows.push_back('{text_in("R", 1'b0), 1'b0, '0});
		dir_rows.push_back('{text_in("M", 1'b0), 1'b0, '0});
		dir_rows.push_back('{text_in("C", 1'b0), 1'b0, '0});
		dir_rows.push_back('{text_in(CH_COMMA, 1'b0), 1'b0, '0});
		dir_rows.push_back('{text_in(CH_COMMA, 1'b0), 1'b0, '0});
		dir_rows.push_back('{text_in(CH_DOLLAR, 1'b0), 1'b0, '0});
		dir_rows.push_back('{text_in(8'h80, 1'b0), 1'b0, '0});
		dir_rows.push_back('{text_in(CH_CR, 1'b0), 1'b0, '0});
		dir_rows.push_back('{store_rd(KIND_RMC, 7'd8), 1'b0, '0});
		dir_rows.push_back('{store_rd(KIND_RMC, 7'd10), 1'b0, '0});
		dir_rows.push_back('{text_in(CH_DOLLAR, 1'b0), 1'b0, '0});
		dir_rows.push_back('{text_in("G", 1'b0), 1'b0, '0});
		dir_rows.push_back('{text_in("Q", 1'b0), 1'b0, '0});
		dir_rows.push_back('{text_in(CH_NUL, 1'b0), 1'b0, '0});
		dir_rows.push_back('{text_in(CH_LF, 1'b1), 1'b1, scan_res(2'b00)});

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i])
			put_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);

		run_phase(7'd3, 7'd2, 1'b1);
		run_phase(7'd0, 7'd80, 1'b0);
		run_phase(7'd80, 7'd0, 1'b0);
		run_phase(7'd1, 7'd1, 1'b0);
		run_phase(RMC_COMMAS_RST, GGA_COMMAS_RST, 1'b0);
		run_phase(CNT_W'($urandom_range(0, 12)), CNT_W'($urandom_range(0, 12)), 1'b0);
		settle();
		repeat (10) @(negedge clk);

		$display("Fed %0d transactions, directed table included, under %0d comma-count settings.",
			item_count, settings_cnt);
		$display("Checked %0d sentence reports (%0d accepted), %0d scan ends, %0d store reads.",
			n_sentence, n_accepted, n_scan, n_read);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

/* sim.f */
rtl/nse_pkg.sv
rtl/nse_ifs.sv
rtl/nmea_sentence_extractor.sv
bench/tb_top.sv
